// File: sv/udwm_pkg.sv
// Shared types, constants and the wide-range lookup for the UTF-8 display width meter.
`default_nettype none

package udwm_pkg;

  localparam int WIDTH_BITS_DEFAULT = 16;
  localparam int LINE_WIDTH_BITS    = 16;
  localparam int TAB_BITS           = 4;
  localparam int CP_BITS            = 21;
  localparam int INC_BITS           = 5;

  localparam logic [TAB_BITS-1:0] TAB_WIDTH_RESET = 4'd4;

  localparam logic [7:0] TAB_BYTE  = 8'h09;
  localparam logic [1:0] CONT_TAG  = 2'h2;
  localparam logic [2:0] LEAD2_TAG = 3'h6;
  localparam logic [3:0] LEAD3_TAG = 4'hE;
  localparam logic [4:0] LEAD4_TAG = 5'h1E;

  typedef logic [CP_BITS-1:0] cp_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       carries_byte;
    logic       end_of_line;
  } item_t;

  // Open multi-byte sequence.
  typedef struct packed {
    logic [1:0] expected;
    logic [1:0] taken;
    cp_t        partial;
  } seq_t;

  localparam int WIDE_RANGE_COUNT = 12;

  localparam cp_t WIDE_LO [WIDE_RANGE_COUNT] = '{
    21'h01100, 21'h02E80, 21'h03041, 21'h03400, 21'h04E00, 21'h0A000,
    21'h0AC00, 21'h0F900, 21'h0FE30, 21'h0FF00, 21'h0FFE0, 21'h20000
  };

  localparam cp_t WIDE_HI [WIDE_RANGE_COUNT] = '{
    21'h0115F, 21'h0303E, 21'h033FF, 21'h04DBF, 21'h09FFF, 21'h0A4CF,
    21'h0D7A3, 21'h0FAFF, 21'h0FE4F, 21'h0FF60, 21'h0FFE6, 21'h3FFFD
  };

  function automatic logic is_wide(cp_t cp);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < WIDE_RANGE_COUNT; k++) begin
      if (cp >= WIDE_LO[k] && cp <= WIDE_HI[k]) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// File: sv/udwm_if.sv
// Handshake channel interfaces: input bytes, line width results and tab width writes.
`default_nettype none

interface udwm_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       carries_byte;
  logic       end_of_line;

  modport source (output valid, output byte_value, output carries_byte,
                  output end_of_line, input ready);
  modport sink   (input valid, input byte_value, input carries_byte,
                  input end_of_line, output ready);
endinterface

interface udwm_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] line_width;

  modport source (output valid, output line_width, input ready);
  modport sink   (input valid, input line_width, output ready);
endinterface

interface udwm_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] tab_width;

  modport source (output valid, output tab_width, input ready);
  modport sink   (input valid, input tab_width, output ready);
endinterface

`default_nettype wire

// File: sv/udwm_step.sv
// One-byte decode step: next sequence state, running width and saturated line width.
`default_nettype none

module udwm_step
  import udwm_pkg::*;
#(
  parameter int WIDTH_BITS = WIDTH_BITS_DEFAULT
) (
  input  item_t                  item,
  input  seq_t                   seq,
  input  logic [WIDTH_BITS-1:0]  run,
  input  logic [TAB_BITS-1:0]    tab_width,
  output seq_t                   seq_next,
  output logic [WIDTH_BITS-1:0]  run_next,
  output logic [WIDTH_BITS-1:0]  width_sat
);

  seq_t                  nxt;
  logic [INC_BITS-1:0]   inc;
  logic [1:0]            taken_inc;
  cp_t                   shifted;
  logic [7:0]            b;
  logic [WIDTH_BITS:0]   sum;

  assign b         = item.byte_value;
  assign taken_inc = seq.taken + 2'd1;
  assign shifted   = {seq.partial[CP_BITS-7:0], b[5:0]};

  always_comb begin
    inc = '0;
    nxt = seq;
    if (item.carries_byte) begin
      if (seq.expected != 2'd0 && b[7:6] == CONT_TAG) begin
        nxt.partial = shifted;
        nxt.taken   = taken_inc;
        if (taken_inc >= seq.expected) begin
          inc = is_wide(shifted) ? INC_BITS'(2) : INC_BITS'(1);
          nxt = '0;
        end
      end else begin
        // broken sequence: lead and taken continuations count one each
        if (seq.expected != 2'd0) begin
          inc = INC_BITS'(1) + INC_BITS'(seq.taken);
          nxt = '0;
        end
        if (b == TAB_BYTE) begin
          inc = inc + INC_BITS'(tab_width);
        end else if (b[7:5] == LEAD2_TAG) begin
          nxt.expected = 2'd1;
          nxt.partial  = cp_t'(b[4:0]);
        end else if (b[7:4] == LEAD3_TAG) begin
          nxt.expected = 2'd2;
          nxt.partial  = cp_t'(b[3:0]);
        end else if (b[7:3] == LEAD4_TAG) begin
          nxt.expected = 2'd3;
          nxt.partial  = cp_t'(b[2:0]);
        end else begin
          inc = inc + INC_BITS'(1);
        end
      end
    end
    if (item.end_of_line && nxt.expected != 2'd0) begin
      inc = inc + INC_BITS'(1) + INC_BITS'(nxt.taken);
    end
  end

  assign sum       = {1'b0, run} + (WIDTH_BITS+1)'(inc);
  assign width_sat = sum[WIDTH_BITS] ? {WIDTH_BITS{1'b1}} : sum[WIDTH_BITS-1:0];

  // line close: return to a clean line
  assign seq_next = item.end_of_line ? seq_t'('0) : nxt;
  assign run_next = item.end_of_line ? '0 : width_sat;

endmodule

`default_nettype wire

// File: sv/utf8_display_width_meter_core.sv
// Top level of the UTF-8 display width meter: input stage, line state and result register.
//
//  channel | dir | payload                                   | beat
//  item    | in  | byte_value, carries_byte, end_of_line     | one byte or line close
//  result  | out | line_width                                | one per end_of_line
//  cfg     | in  | tab_width                                 | one register write
//
// One item per cycle sustained unless a line close waits on a stalled result.
// A byte is registered on entry and decoded against the line state in the next
// cycle; a line width reaches the result register when its closing item advances.
// The decode, twelve range compares and one saturating add form the state loop.
// Reset clears the line state, both valid flags and sets tab_width to 4.
// A stalled result holds the stage with the closing item; other bytes keep flowing.
`default_nettype none

module utf8_display_width_meter_core
  import udwm_pkg::*;
#(
  parameter int WIDTH_BITS = WIDTH_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  udwm_item_if.sink         item,
  udwm_result_if.source     result,
  udwm_cfg_if.sink          cfg
);

  logic [TAB_BITS-1:0]   tab_width;
  logic                  stage_valid;
  item_t                 stage;
  seq_t                  seq;
  logic [WIDTH_BITS-1:0] run;
  logic                  out_valid;
  logic [LINE_WIDTH_BITS-1:0] line_width;

  seq_t                  seq_next;
  logic [WIDTH_BITS-1:0] run_next;
  logic [WIDTH_BITS-1:0] width_sat;
  logic [WIDTH_BITS+LINE_WIDTH_BITS-1:0] width_ext;
  logic                  advance;
  logic                  load_result;

  assign advance     = stage_valid && (!stage.end_of_line || !out_valid || result.ready);
  assign load_result = advance && stage.end_of_line;
  assign item.ready  = !stage_valid || advance;
  assign cfg.ready   = 1'b1;

  assign width_ext = {{LINE_WIDTH_BITS{1'b0}}, width_sat};

  udwm_step #(
    .WIDTH_BITS(WIDTH_BITS)
  ) u_step (
    .item      (stage),
    .seq       (seq),
    .run       (run),
    .tab_width (tab_width),
    .seq_next  (seq_next),
    .run_next  (run_next),
    .width_sat (width_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_width <= TAB_WIDTH_RESET;
    end else if (cfg.valid) begin
      tab_width <= cfg.tab_width;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage <= '{byte_value: item.byte_value, carries_byte: item.carries_byte,
                 end_of_line: item.end_of_line};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= '0;
      run <= '0;
    end else if (advance) begin
      seq <= seq_next;
      run <= run_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      line_width <= width_ext[LINE_WIDTH_BITS-1:0];
    end
  end

  assign result.valid      = out_valid;
  assign result.line_width = line_width;

  // no open sequence leaves no stray bits behind
  a_idle_seq_clean: assert property (@(posedge clk) disable iff (rst)
    seq.expected == 2'd0 |-> seq.taken == 2'd0 && seq.partial == '0)
    else $error("sequence state not clean while idle");

  a_taken_below_expected: assert property (@(posedge clk) disable iff (rst)
    seq.expected != 2'd0 |-> seq.taken < seq.expected)
    else $error("continuation count reached expected without closing");

  a_close_clears_line: assert property (@(posedge clk) disable iff (rst)
    load_result |=> run == '0 && seq.expected == 2'd0 && out_valid)
    else $error("line close did not clear state or raise result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !load_result |=> !out_valid)
    else $error("result raised without a line close");

endmodule

`default_nettype wire
